@@ design/tbpe_pkg.sv @@
// ----------------------------------------------------------------------------
// tbpe_pkg
// shared types, segment table and helpers for the transfer body encoder
// ----------------------------------------------------------------------------
package tbpe_pkg;

  localparam logic [5:0] SEG_LAST = 6'd41;

  localparam logic [7:0] TAG_0A = 8'h0A;
  localparam logic [7:0] TAG_12 = 8'h12;
  localparam logic [7:0] TAG_18 = 8'h18;
  localparam logic [7:0] TAG_10 = 8'h10;
  localparam logic [7:0] TAG_08 = 8'h08;
  localparam logic [7:0] TAG_22 = 8'h22;
  localparam logic [7:0] TAG_72 = 8'h72;

  typedef enum logic [4:0] {
    S_T0A, S_T12, S_T18, S_T10, S_T08, S_T22, S_T72,
    S_LT2, S_LTS, S_LACP, S_LACN, S_LDUR, S_LT3, S_LTL,
    S_LLEG1, S_LACS, S_LLEG2, S_LACR,
    S_SEC, S_NAN, S_PAY, S_NOD, S_FEE, S_DUR, S_SND, S_RCV, S_ZZ1, S_ZZ2
  } src_t;

  typedef enum logic [3:0] {
    C_ALL, C_SEC, C_NAN, C_PAY, C_NOD, C_FEE, C_DUR, C_SND, C_RCV
  } cond_t;

  typedef struct packed {
    src_t  src;
    cond_t cond;
  } seg_t;

  typedef struct packed {
    logic       capture;
    logic       calc_len;
    logic       calc_sum;
    logic       emit;
    logic       flush;
    logic       push_err;
    logic [5:0] seg;
  } cmd_t;

  typedef struct packed {
    logic bad;
    logic seg_skip;
    logic seg_end;
    logic can_emit;
    logic out_free;
  } sts_t;

  // body layout, one field item (tag, length or varint value) per entry
  function automatic seg_t seg_info(input logic [5:0] seg);
    seg_t r;
    unique case (seg)
      6'd0:  r = '{S_T0A, C_ALL};
      6'd1:  r = '{S_LT2, C_ALL};
      6'd2:  r = '{S_T0A, C_ALL};
      6'd3:  r = '{S_LTS, C_ALL};
      6'd4:  r = '{S_T08, C_SEC};
      6'd5:  r = '{S_SEC, C_SEC};
      6'd6:  r = '{S_T10, C_NAN};
      6'd7:  r = '{S_NAN, C_NAN};
      6'd8:  r = '{S_T12, C_ALL};
      6'd9:  r = '{S_LACP, C_ALL};
      6'd10: r = '{S_T18, C_PAY};
      6'd11: r = '{S_PAY, C_PAY};
      6'd12: r = '{S_T12, C_ALL};
      6'd13: r = '{S_LACN, C_ALL};
      6'd14: r = '{S_T18, C_NOD};
      6'd15: r = '{S_NOD, C_NOD};
      6'd16: r = '{S_T18, C_FEE};
      6'd17: r = '{S_FEE, C_FEE};
      6'd18: r = '{S_T22, C_ALL};
      6'd19: r = '{S_LDUR, C_ALL};
      6'd20: r = '{S_T08, C_DUR};
      6'd21: r = '{S_DUR, C_DUR};
      6'd22: r = '{S_T72, C_ALL};
      6'd23: r = '{S_LT3, C_ALL};
      6'd24: r = '{S_T0A, C_ALL};
      6'd25: r = '{S_LTL, C_ALL};
      6'd26: r = '{S_T0A, C_ALL};
      6'd27: r = '{S_LLEG1, C_ALL};
      6'd28: r = '{S_T0A, C_ALL};
      6'd29: r = '{S_LACS, C_ALL};
      6'd30: r = '{S_T18, C_SND};
      6'd31: r = '{S_SND, C_SND};
      6'd32: r = '{S_T10, C_ALL};
      6'd33: r = '{S_ZZ1, C_ALL};
      6'd34: r = '{S_T0A, C_ALL};
      6'd35: r = '{S_LLEG2, C_ALL};
      6'd36: r = '{S_T0A, C_ALL};
      6'd37: r = '{S_LACR, C_ALL};
      6'd38: r = '{S_T18, C_RCV};
      6'd39: r = '{S_RCV, C_RCV};
      6'd40: r = '{S_T10, C_ALL};
      6'd41: r = '{S_ZZ2, C_ALL};
      default: r = '{S_T0A, C_ALL};
    endcase
    return r;
  endfunction

  // number of varint bytes, 1 to 10
  function automatic logic [3:0] varint_size(input logic [63:0] v);
    logic [3:0] n;
    n = 4'd1;
    for (int i = 1; i < 10; i++) begin
      if ((v >> (7 * i)) != 64'd0) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

@@ design/tbpe_in_if.sv @@
// ----------------------------------------------------------------------------
// tbpe_in_if
// request channel carrying one transfer descriptor
// ----------------------------------------------------------------------------
interface tbpe_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] start_seconds;
  logic [31:0] start_nanos;
  logic [63:0] payer_account;
  logic [63:0] node_account;
  logic [63:0] fee_amount;
  logic [63:0] duration_seconds;
  logic [63:0] sender_account;
  logic [63:0] receiver_account;
  logic [63:0] transfer_amount;

  modport source (
    output valid, start_seconds, start_nanos, payer_account, node_account,
           fee_amount, duration_seconds, sender_account, receiver_account,
           transfer_amount,
    input  ready
  );
  modport sink (
    input  valid, start_seconds, start_nanos, payer_account, node_account,
           fee_amount, duration_seconds, sender_account, receiver_account,
           transfer_amount,
    output ready
  );
endinterface

@@ design/tbpe_out_if.sv @@
// ----------------------------------------------------------------------------
// tbpe_out_if
// result channel carrying packed body bytes
// ----------------------------------------------------------------------------
interface tbpe_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        last;
  logic        error;

  modport source (output valid, data_word, byte_count, last, error, input ready);
  modport sink (input valid, data_word, byte_count, last, error, output ready);
endinterface

@@ design/tbpe_datapath.sv @@
// ----------------------------------------------------------------------------
// tbpe_datapath
// field registers, length precompute, varint byte generator and word packer
// ----------------------------------------------------------------------------
module tbpe_datapath
  import tbpe_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [7:0]   cfg_wdata,
  input  cmd_t         cmd,
  output sts_t         sts,
  tbpe_in_if.sink      in_ch,
  tbpe_out_if.source   out_ch
);

  logic [7:0]  capacity;
  logic [63:0] sec, pay, nod, fee, dur, snd, rcv, amt;
  logic [31:0] nan;
  logic [3:0]  l_sec, l_nan, l_pay, l_nod, l_fee, l_dur, l_snd, l_rcv, l_zz1, l_zz2;
  logic [6:0]  ts, acp, acn, dlen, acs, acr, leg1, leg2, tl, t3, t2, feep;
  logic [63:0] zz1, zz2;
  logic [63:0] vr;
  logic        first;
  logic [63:0] wbuf;
  logic [3:0]  wcnt;
  logic        out_valid;
  logic [7:0]  body;
  seg_t        info;
  logic        present;
  logic [63:0] srcv, v;
  logic [7:0]  obyte;
  logic        push_word;

  function automatic logic [6:0] opt_len(input logic [3:0] l, input logic nz);
    return nz ? 7'(l) + 7'd1 : 7'd0;
  endfunction

  assign zz2 = {amt[62:0], 1'b0};
  assign zz1 = zz2 - 64'd1;

  assign body = 8'(t2) + 8'(acn) + 8'(feep) + 8'(dlen) + 8'(t3) + 8'd8;

  always_comb begin
    info = seg_info(cmd.seg);
    case (info.cond)
      C_SEC:   present = sec != 64'd0;
      C_NAN:   present = nan != 32'd0;
      C_PAY:   present = pay != 64'd0;
      C_NOD:   present = nod != 64'd0;
      C_FEE:   present = fee != 64'd0;
      C_DUR:   present = dur != 64'd0;
      C_SND:   present = snd != 64'd0;
      C_RCV:   present = rcv != 64'd0;
      default: present = 1'b1;
    endcase
    case (info.src)
      S_T0A:   srcv = 64'(TAG_0A);
      S_T12:   srcv = 64'(TAG_12);
      S_T18:   srcv = 64'(TAG_18);
      S_T10:   srcv = 64'(TAG_10);
      S_T08:   srcv = 64'(TAG_08);
      S_T22:   srcv = 64'(TAG_22);
      S_T72:   srcv = 64'(TAG_72);
      S_LT2:   srcv = 64'(t2);
      S_LTS:   srcv = 64'(ts);
      S_LACP:  srcv = 64'(acp);
      S_LACN:  srcv = 64'(acn);
      S_LDUR:  srcv = 64'(dlen);
      S_LT3:   srcv = 64'(t3);
      S_LTL:   srcv = 64'(tl);
      S_LLEG1: srcv = 64'(leg1);
      S_LACS:  srcv = 64'(acs);
      S_LLEG2: srcv = 64'(leg2);
      S_LACR:  srcv = 64'(acr);
      S_SEC:   srcv = sec;
      S_NAN:   srcv = 64'(nan);
      S_PAY:   srcv = pay;
      S_NOD:   srcv = nod;
      S_FEE:   srcv = fee;
      S_DUR:   srcv = dur;
      S_SND:   srcv = snd;
      S_RCV:   srcv = rcv;
      S_ZZ1:   srcv = zz1;
      S_ZZ2:   srcv = zz2;
      default: srcv = 64'd0;
    endcase
    v     = first ? srcv : vr;
    obyte = {v[63:7] != 57'd0, v[6:0]};
  end

  assign sts.bad      = (amt == 64'd0) || amt[63] || (body > capacity);
  assign sts.seg_skip = !present;
  assign sts.seg_end  = v[63:7] == 57'd0;
  assign sts.can_emit = wcnt != 4'd8;
  assign sts.out_free = !out_valid || out_ch.ready;

  assign push_word = sts.out_free && ((wcnt == 4'd8) || cmd.flush);

  assign out_ch.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= 8'd255;
      out_valid <= 1'b0;
      wcnt      <= 4'd0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (sts.out_free) begin
        out_valid <= push_word || cmd.push_err;
      end
      if (cmd.capture || push_word) begin
        wcnt <= 4'd0;
      end else if (cmd.emit) begin
        wcnt <= wcnt + 4'd1;
      end
    end
    if (cmd.capture) begin
      sec <= in_ch.start_seconds;
      nan <= in_ch.start_nanos;
      pay <= in_ch.payer_account;
      nod <= in_ch.node_account;
      fee <= in_ch.fee_amount;
      dur <= in_ch.duration_seconds;
      snd <= in_ch.sender_account;
      rcv <= in_ch.receiver_account;
      amt <= in_ch.transfer_amount;
    end
    if (cmd.capture) begin
      first <= 1'b1;
    end else if (cmd.emit) begin
      first <= v[63:7] == 57'd0;
    end
    if (cmd.capture || push_word) begin
      wbuf <= 64'd0;
    end else if (cmd.emit) begin
      wbuf[8 * wcnt[2:0] +: 8] <= obyte;
    end
    if (cmd.calc_len) begin
      l_sec <= varint_size(sec);
      l_nan <= varint_size(64'(nan));
      l_pay <= varint_size(pay);
      l_nod <= varint_size(nod);
      l_fee <= varint_size(fee);
      l_dur <= varint_size(dur);
      l_snd <= varint_size(snd);
      l_rcv <= varint_size(rcv);
      l_zz1 <= varint_size(zz1);
      l_zz2 <= varint_size(zz2);
    end
    if (cmd.calc_sum) begin
      ts   <= opt_len(l_sec, sec != 64'd0) + opt_len(l_nan, nan != 32'd0);
      acp  <= opt_len(l_pay, pay != 64'd0);
      acn  <= opt_len(l_nod, nod != 64'd0);
      feep <= opt_len(l_fee, fee != 64'd0);
      dlen <= opt_len(l_dur, dur != 64'd0);
      acs  <= opt_len(l_snd, snd != 64'd0);
      acr  <= opt_len(l_rcv, rcv != 64'd0);
      leg1 <= opt_len(l_snd, snd != 64'd0) + 7'(l_zz1) + 7'd3;
      leg2 <= opt_len(l_rcv, rcv != 64'd0) + 7'(l_zz2) + 7'd3;
      tl   <= opt_len(l_snd, snd != 64'd0) + 7'(l_zz1) + opt_len(l_rcv, rcv != 64'd0)
              + 7'(l_zz2) + 7'd10;
      t3   <= opt_len(l_snd, snd != 64'd0) + 7'(l_zz1) + opt_len(l_rcv, rcv != 64'd0)
              + 7'(l_zz2) + 7'd12;
      t2   <= opt_len(l_sec, sec != 64'd0) + opt_len(l_nan, nan != 32'd0)
              + opt_len(l_pay, pay != 64'd0) + 7'd4;
    end
    if (cmd.emit) begin
      vr <= v >> 7;
    end
    if (sts.out_free) begin
      out_ch.data_word  <= cmd.push_err ? 64'd0 : wbuf;
      out_ch.byte_count <= cmd.push_err ? 4'd0 : wcnt;
      out_ch.last       <= cmd.push_err || cmd.flush;
      out_ch.error      <= cmd.push_err;
    end
  end

endmodule

@@ design/tbpe_ctrl.sv @@
// ----------------------------------------------------------------------------
// tbpe_ctrl
// sequencer: length precompute, capacity check, error result on a bad request, else walk and flush the body layout
// ----------------------------------------------------------------------------
module tbpe_ctrl
  import tbpe_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output cmd_t cmd,
  input  sts_t sts
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_LEN, ST_SUM, ST_CHECK, ST_EMIT, ST_FLUSH, ST_ERR
  } state_t;

  state_t     state;
  logic [5:0] seg;
  logic       advance;

  assign in_ready = state == ST_IDLE;

  always_comb begin
    cmd          = '0;
    cmd.seg      = seg;
    cmd.capture  = in_ready && in_valid;
    cmd.calc_len = state == ST_LEN;
    cmd.calc_sum = state == ST_SUM;
    cmd.emit     = (state == ST_EMIT) && !sts.seg_skip && sts.can_emit;
    cmd.flush    = state == ST_FLUSH;
    cmd.push_err = state == ST_ERR;
    advance      = (state == ST_EMIT) && (sts.seg_skip || (cmd.emit && sts.seg_end));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      seg   <= 6'd0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state <= ST_LEN;
          end
        end
        ST_LEN:   state <= ST_SUM;
        ST_SUM:   state <= ST_CHECK;
        ST_CHECK: begin
          seg   <= 6'd0;
          state <= sts.bad ? ST_ERR : ST_EMIT;
        end
        ST_EMIT: begin
          if (advance) begin
            if (seg == SEG_LAST) begin
              state <= ST_FLUSH;
            end else begin
              seg <= seg + 6'd1;
            end
          end
        end
        ST_FLUSH, ST_ERR: begin
          if (sts.out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/transfer_body_protobuf_encoder_unit.sv @@
// sequence: length precompute, sums and capacity check after acceptance, then one
// body byte or skipped field item per cycle, held while a full word is pending
// throughput: one request at a time, set by the single varint byte generator
// error requests give their single result after the capacity check
// rst is synchronous: capacity returns to 255 and the sequencer to idle
// ----------------------------------------------------------------------------
// transfer_body_protobuf_encoder_unit
// encodes one transfer descriptor into protobuf body bytes, eight per word
// ----------------------------------------------------------------------------
module transfer_body_protobuf_encoder_unit
  import tbpe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  tbpe_in_if.sink     in_ch,
  tbpe_out_if.source  out_ch
);

  cmd_t cmd;
  sts_t sts;

  tbpe_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  tbpe_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

endmodule

@@ tb/tb_transfer_body_protobuf_encoder_unit.sv @@
// ----------------------------------------------------------------------------
// tb_transfer_body_protobuf_encoder_unit
// self-checking bench: random and directed transfer descriptors are encoded by
// a local protobuf body builder and compared word by word with the block
// ----------------------------------------------------------------------------
module tb_transfer_body_protobuf_encoder_unit;
  import tbpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  typedef struct {
    logic [63:0] start_seconds;
    logic [31:0] start_nanos;
    logic [63:0] payer_account;
    logic [63:0] node_account;
    logic [63:0] fee_amount;
    logic [63:0] duration_seconds;
    logic [63:0] sender_account;
    logic [63:0] receiver_account;
    logic [63:0] transfer_amount;
    bit          drain_first;
  } transfer_t;

  typedef struct {
    logic [63:0] data_word;
    logic [3:0]  byte_count;
    logic        last;
    logic        error;
  } body_word_t;

  localparam logic [63:0] AMOUNT_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam int          IDLE_PCT     = 36;
  localparam int          SETTLE       = 200;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'd0;

  tbpe_in_if  in_bus ();
  tbpe_out_if out_bus ();

  transfer_body_protobuf_encoder_unit u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_bus),
    .out_ch    (out_bus)
  );

  always #5 clk = ~clk;

  transfer_t  pending_transfers[$];
  body_word_t expected_words[$];
  transfer_t  cur_transfer;
  logic [7:0] capacity_model = 8'd255;
  bit         no_idle = 1'b0;
  int         fail_count = 0;
  int         sent_count = 0;
  int         word_count = 0;
  int         error_count = 0;

  // ---- body builder ----
  function automatic byte_q_t varint_bytes(input logic [63:0] v);
    byte_q_t q;
    logic [7:0] b;
    q = {};
    do begin
      b = {1'b0, v[6:0]};
      v = v >> 7;
      if (v != 64'd0) b[7] = 1'b1;
      q.push_back(b);
    end while (v != 64'd0);
    return q;
  endfunction

  function automatic byte_q_t uint_field(input int field, input logic [63:0] v);
    byte_q_t q;
    q = {};
    if (v != 64'd0) q = {varint_bytes(64'(field) << 3), varint_bytes(v)};
    return q;
  endfunction

  function automatic byte_q_t sub_field(input int field, input byte_q_t s);
    byte_q_t q;
    q = {varint_bytes((64'(field) << 3) | 64'd2), varint_bytes(64'(s.size())), s};
    return q;
  endfunction

  function automatic byte_q_t leg_msg(input logic [63:0] acct, input logic [63:0] zz);
    byte_q_t q;
    q = {sub_field(1, uint_field(3, acct)), uint_field(2, zz)};
    return q;
  endfunction

  function automatic byte_q_t transfer_body(input transfer_t t);
    byte_q_t ts, tid, lst, body;
    logic [63:0] a;
    a    = t.transfer_amount;
    ts   = {uint_field(1, t.start_seconds), uint_field(2, {32'd0, t.start_nanos})};
    tid  = {sub_field(1, ts), sub_field(2, uint_field(3, t.payer_account))};
    body = {sub_field(1, tid), sub_field(2, uint_field(3, t.node_account)),
            uint_field(3, t.fee_amount), sub_field(4, uint_field(1, t.duration_seconds))};
    // sender leg carries -amount, zigzag gives 2a-1
    lst  = {sub_field(1, leg_msg(t.sender_account, (a << 1) - 64'd1)),
            sub_field(1, leg_msg(t.receiver_account, a << 1))};
    body = {body, sub_field(14, sub_field(1, lst))};
    return body;
  endfunction

  function automatic void queue_body_words(input transfer_t t);
    byte_q_t    body;
    body_word_t w;
    int         n, k;
    if (t.transfer_amount == 64'd0 || t.transfer_amount > AMOUNT_LIMIT) begin
      expected_words.push_back('{64'd0, 4'd0, 1'b1, 1'b1});
      return;
    end
    body = transfer_body(t);
    if (body.size() > int'(capacity_model)) begin
      expected_words.push_back('{64'd0, 4'd0, 1'b1, 1'b1});
      return;
    end
    n = body.size();
    for (k = 0; k < n; k += 8) begin
      w.data_word  = 64'd0;
      w.byte_count = 4'((n - k > 8) ? 8 : n - k);
      for (int j = 0; j < int'(w.byte_count); j++) w.data_word[8*j +: 8] = body[k + j];
      w.last  = (k + 8 >= n);
      w.error = 1'b0;
      expected_words.push_back(w);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  // ---- request driver ----
  always @(posedge clk) begin
    if (rst) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        queue_body_words(cur_transfer);
        sent_count++;
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_transfers.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)
            && !(pending_transfers[0].drain_first && expected_words.size() != 0)) begin
          cur_transfer = pending_transfers.pop_front();
          in_bus.valid            <= 1'b1;
          in_bus.start_seconds    <= cur_transfer.start_seconds;
          in_bus.start_nanos      <= cur_transfer.start_nanos;
          in_bus.payer_account    <= cur_transfer.payer_account;
          in_bus.node_account     <= cur_transfer.node_account;
          in_bus.fee_amount       <= cur_transfer.fee_amount;
          in_bus.duration_seconds <= cur_transfer.duration_seconds;
          in_bus.sender_account   <= cur_transfer.sender_account;
          in_bus.receiver_account <= cur_transfer.receiver_account;
          in_bus.transfer_amount  <= cur_transfer.transfer_amount;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // ---- result monitor ----
  always @(posedge clk) begin
    body_word_t w;
    if (rst) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word", out_bus.data_word, 64'd0);
        end else begin
          w = expected_words.pop_front();
          word_count++;
          if (w.error) error_count++;
          if (out_bus.data_word !== w.data_word)
            report_mismatch("data_word", out_bus.data_word, w.data_word);
          if (out_bus.byte_count !== w.byte_count)
            report_mismatch("byte_count", 64'(out_bus.byte_count), 64'(w.byte_count));
          if (out_bus.last !== w.last)
            report_mismatch("last", 64'(out_bus.last), 64'(w.last));
          if (out_bus.error !== w.error)
            report_mismatch("error", 64'(out_bus.error), 64'(w.error));
        end
      end
      out_bus.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // ---- stimulus helpers ----
  function automatic logic [63:0] pick_value();
    logic [63:0] v;
    case ($urandom_range(6))
      0: v = 64'd0;
      1: v = ALL_ONES;
      2: v = {$urandom, $urandom};
      3: v = {$urandom, $urandom} >> $urandom_range(63);
      4: v = 64'($urandom_range(1, 300));
      // varint byte boundaries
      5: v = (64'd1 << (7 * $urandom_range(1, 9))) - 64'($urandom_range(1));
      default: v = {$urandom, $urandom} >> (7 * $urandom_range(9));
    endcase
    return v;
  endfunction

  function automatic transfer_t random_transfer();
    transfer_t t;
    t.start_seconds    = pick_value();
    t.start_nanos      = 32'(pick_value());
    t.payer_account    = pick_value();
    t.node_account     = pick_value();
    t.fee_amount       = pick_value();
    t.duration_seconds = pick_value();
    t.sender_account   = pick_value();
    t.receiver_account = pick_value();
    if ($urandom_range(99) < 85) begin
      t.transfer_amount = pick_value() & AMOUNT_LIMIT;
      if (t.transfer_amount == 64'd0) t.transfer_amount = 64'd1;
    end else begin
      case ($urandom_range(2))
        0: t.transfer_amount = 64'd0;
        1: t.transfer_amount = AMOUNT_LIMIT + 64'd1;
        default: t.transfer_amount = {1'b1, $urandom, 31'($urandom)};
      endcase
    end
    t.drain_first = 1'b0;
    return t;
  endfunction

  function automatic transfer_t flat_transfer(input logic [63:0] v, input logic [63:0] a);
    transfer_t t;
    t = '{v, v[31:0], v, v, v, v, v, v, a, 1'b0};
    return t;
  endfunction

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_transfers.size() != 0 || in_bus.valid || expected_words.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [7:0] v);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    capacity_model = v;
  endtask

  task automatic push_random(input int n);
    repeat (n) pending_transfers.push_back(random_transfer());
  endtask

  // ---- main sequence ----
  initial begin
    transfer_t t;
    int        blen;
    in_bus.valid = 1'b0;
    {in_bus.start_seconds, in_bus.start_nanos, in_bus.payer_account} = '0;
    {in_bus.node_account, in_bus.fee_amount, in_bus.duration_seconds} = '0;
    {in_bus.sender_account, in_bus.receiver_account, in_bus.transfer_amount} = '0;
    out_bus.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    set_capacity(8'd255);
    // directed: smallest and largest bodies, invalid amounts, each field alone
    pending_transfers.push_back(flat_transfer(64'd0, 64'd1));
    pending_transfers.push_back(flat_transfer(ALL_ONES, AMOUNT_LIMIT));
    pending_transfers.push_back(flat_transfer(ALL_ONES, 64'd0));
    pending_transfers.push_back(flat_transfer(64'd5, AMOUNT_LIMIT + 64'd1));
    pending_transfers.push_back(flat_transfer(64'd5, ALL_ONES));
    pending_transfers.push_back(flat_transfer(64'd127, 64'd64));
    pending_transfers.push_back(flat_transfer(64'd128, 64'd63));
    for (int f = 0; f < 8; f++) begin
      t = flat_transfer(64'd0, 64'd2);
      case (f)
        0: t.start_seconds    = ALL_ONES;
        1: t.start_nanos      = 32'hFFFF_FFFF;
        2: t.payer_account    = ALL_ONES;
        3: t.node_account     = ALL_ONES;
        4: t.fee_amount       = ALL_ONES;
        5: t.duration_seconds = ALL_ONES;
        6: t.sender_account   = ALL_ONES;
        default: t.receiver_account = ALL_ONES;
      endcase
      pending_transfers.push_back(t);
    end
    // pause until the block is empty before this one
    t = random_transfer();
    t.drain_first = 1'b1;
    pending_transfers.push_back(t);

    // body length exactly at the capacity, then one byte over
    t = random_transfer();
    t.transfer_amount = 64'd1000;
    blen = transfer_body(t).size();
    set_capacity(8'(blen));
    pending_transfers.push_back(t);
    set_capacity(8'(blen - 1));
    pending_transfers.push_back(t);

    set_capacity(8'd255);
    push_random(40);
    wait_drained();
    no_idle = 1'b1;
    push_random(40);
    wait_drained();
    no_idle = 1'b0;
    t = random_transfer();
    t.drain_first = 1'b1;
    pending_transfers.push_back(t);
    push_random(20);

    set_capacity(8'd0);
    push_random(12);
    set_capacity(8'd60);
    push_random(30);
    set_capacity(8'($urandom_range(20, 254)));
    push_random(30);
    set_capacity(8'd127);
    push_random(30);

    wait_drained();
    $display("sent %0d descriptors, checked %0d result words (%0d error results)",
             sent_count, word_count, error_count);
    $display("capacity settings 0, 60, 127, 255, a random one and the length boundary");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #10ms;
    $display("timeout with %0d results outstanding", expected_words.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
